@@ sv/assert_macros.svh @@
// Assertion macros for the point-in-triangle RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PIT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PIT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define PIT_ASSERT(lbl, clk, rst_n, prop)
`define PIT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ sv/pit_pkg.sv @@
// Shared constants for the point-in-triangle test.
// Used by every module of the block; depends on nothing.
package pit_pkg;
    localparam int COORD_BITS_DEF     = 16;
    localparam int QUOT_FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH        = 2;
    localparam int IDX_W              = 3;

    localparam logic [IDX_W-1:0] REG_A_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_A_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_B_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_B_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_C_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_C_Y = 3'd5;
endpackage

@@ sv/point_in_triangle_test.sv @@
// Top level of the barycentric point-in-triangle test.
// Depends on pit_pkg, pit_front, pit_queue, pit_back and assert_macros.svh.
//
// Usage: write the six vertex registers (A.x, A.y, B.x, B.y, C.x, C.y, indexes
// 0 to 5, Q12.4 signed) through i_cfg_we, i_cfg_idx and i_cfg_data while the
// block is idle. Writes to other indexes are ignored. A point is taken at each
// rising edge where i_start is high and o_busy is low. One item is accepted
// per clock while o_busy is low, and each item gives one result.
// The result appears on o_inside_res and o_degenerate with o_done high for one
// cycle, after the front pipeline, the queue, the back input register, the
// divider pipeline and the output register. The divider pipeline resolves one
// quotient bit per stage for both weights in parallel.
// Reset clears all vertex registers, which forms a degenerate triangle, and
// empties the pipeline. The receiver cannot stall; results leave in order.
`include "assert_macros.svh"
module point_in_triangle_test
    import pit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int QUOT_FRAC_BITS = QUOT_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic                  i_cfg_we,
    input  logic [IDX_W-1:0]      i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    output logic                  o_done,
    output logic                  o_inside_res,
    output logic                  o_degenerate
);
    localparam int XW = 2 * COORD_BITS + 3;

    logic [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic                  accept, f_valid, q_empty, q_full;
    logic [XW-1:0]         f_nu, f_nv, f_den, b_nu, b_nv, b_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_bx <= '0;
            r_by <= '0;
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_A_X: r_ax <= i_cfg_data;
                REG_A_Y: r_ay <= i_cfg_data;
                REG_B_X: r_bx <= i_cfg_data;
                REG_B_Y: r_by <= i_cfg_data;
                REG_C_X: r_cx <= i_cfg_data;
                REG_C_Y: r_cy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = i_start && !o_busy;
    assign o_busy = q_full;

    pit_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_bx    (r_bx),
        .i_by    (r_by),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .o_valid (f_valid),
        .o_nu    (f_nu),
        .o_nv    (f_nv),
        .o_den   (f_den)
    );

    pit_queue #(.WIDTH(3 * XW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_nu, f_nv, f_den}),
        .i_pop   (1'b1),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_data  ({b_nu, b_nv, b_den})
    );

    pit_back #(.COORD_BITS(COORD_BITS), .QUOT_FRAC_BITS(QUOT_FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (!q_empty),
        .i_nu         (b_nu),
        .i_nv         (b_nv),
        .i_den        (b_den),
        .o_done       (o_done),
        .o_inside     (o_inside_res),
        .o_degenerate (o_degenerate)
    );

    `PIT_ASSERT(a_deg_not_inside, i_clk, i_rst_n, o_degenerate |-> !o_inside_res)
    `PIT_ASSERT(a_quiet_idle, i_clk, i_rst_n, !o_done |-> (!o_inside_res && !o_degenerate))
    `PIT_ASSERT_NEVER(a_queue_never_full, i_clk, i_rst_n, q_full)
endmodule

@@ sv/pit_front.sv @@
// Front part: takes a point, forms the vectors and the three cross products.
// Depends on pit_pkg.
module pit_front
    import pit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [COORD_BITS-1:0]     i_px,
    input  logic [COORD_BITS-1:0]     i_py,
    input  logic [COORD_BITS-1:0]     i_ax,
    input  logic [COORD_BITS-1:0]     i_ay,
    input  logic [COORD_BITS-1:0]     i_bx,
    input  logic [COORD_BITS-1:0]     i_by,
    input  logic [COORD_BITS-1:0]     i_cx,
    input  logic [COORD_BITS-1:0]     i_cy,
    output logic                      o_valid,
    output logic [2*COORD_BITS+2:0]   o_nu,
    output logic [2*COORD_BITS+2:0]   o_nv,
    output logic [2*COORD_BITS+2:0]   o_den
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int XW = 2 * COORD_BITS + 3;

    logic                 r_v1, r_v2, r_v3;
    logic signed [DW-1:0] r_qx, r_qy, r_e0x, r_e0y, r_e1x, r_e1y;
    logic signed [PW-1:0] r_qx_e1y, r_qy_e1x, r_e0x_qy, r_e0y_qx, r_e0x_e1y, r_e0y_e1x;
    logic signed [XW-1:0] r_nu, r_nv, r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qx  <= $signed({i_px[COORD_BITS-1], i_px}) - $signed({i_ax[COORD_BITS-1], i_ax});
        r_qy  <= $signed({i_py[COORD_BITS-1], i_py}) - $signed({i_ay[COORD_BITS-1], i_ay});
        r_e0x <= $signed({i_cx[COORD_BITS-1], i_cx}) - $signed({i_ax[COORD_BITS-1], i_ax});
        r_e0y <= $signed({i_cy[COORD_BITS-1], i_cy}) - $signed({i_ay[COORD_BITS-1], i_ay});
        r_e1x <= $signed({i_bx[COORD_BITS-1], i_bx}) - $signed({i_ax[COORD_BITS-1], i_ax});
        r_e1y <= $signed({i_by[COORD_BITS-1], i_by}) - $signed({i_ay[COORD_BITS-1], i_ay});

        r_qx_e1y  <= PW'(r_qx * r_e1y);
        r_qy_e1x  <= PW'(r_qy * r_e1x);
        r_e0x_qy  <= PW'(r_e0x * r_qy);
        r_e0y_qx  <= PW'(r_e0y * r_qx);
        r_e0x_e1y <= PW'(r_e0x * r_e1y);
        r_e0y_e1x <= PW'(r_e0y * r_e1x);

        r_nu  <= $signed({r_qx_e1y[PW-1], r_qx_e1y}) - $signed({r_qy_e1x[PW-1], r_qy_e1x});
        r_nv  <= $signed({r_e0x_qy[PW-1], r_e0x_qy}) - $signed({r_e0y_qx[PW-1], r_e0y_qx});
        r_den <= $signed({r_e0x_e1y[PW-1], r_e0x_e1y})
               - $signed({r_e0y_e1x[PW-1], r_e0y_e1x});
    end

    assign o_valid = r_v3;
    assign o_nu    = r_nu;
    assign o_nv    = r_nv;
    assign o_den   = r_den;
endmodule

@@ sv/pit_queue.sv @@
// Short queue between the front and the back part.
// Depends on pit_pkg.
module pit_queue
    import pit_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign do_pop  = i_pop && !o_empty;
    assign do_push = i_push && (!o_full || do_pop);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

@@ sv/pit_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, flags overflow at four.
// Depends on pit_pkg.
module pit_div
    import pit_pkg::*;
#(
    parameter int MW = 34,
    parameter int QUOT_FRAC_BITS = QUOT_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [MW-1:0]             i_num,
    input  logic [MW-1:0]             i_den,
    output logic                      o_valid,
    output logic                      o_ovf,
    output logic [QUOT_FRAC_BITS+1:0] o_quot
);
    localparam int F  = QUOT_FRAC_BITS;
    localparam int NS = F + 2;
    localparam int RW = MW + 2;

    logic          r_v   [0:NS];
    logic          r_ovf [0:NS];
    logic [RW-1:0] r_rem [0:NS];
    logic [MW-1:0] r_d   [0:NS];
    logic [F+1:0]  r_q   [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf[0] <= {2'b00, i_num} >= {i_den, 2'b00};
        r_rem[0] <= RW'(i_num);
        r_d[0]   <= i_den;
        r_q[0]   <= '0;
    end

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [RW-1:0] cand, cmpd;
        logic          qbit;

        always_comb begin
            if (j < 2) begin
                cand = r_rem[j];
                cmpd = RW'({2'b00, r_d[j]} << (1 - j));
            end else begin
                cand = {r_rem[j][RW-2:0], 1'b0};
                cmpd = RW'(r_d[j]);
            end
            qbit = (cand >= cmpd);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_ovf[j+1] <= r_ovf[j];
            r_rem[j+1] <= qbit ? cand - cmpd : cand;
            r_d[j+1]   <= r_d[j];
            r_q[j+1]   <= {r_q[j][F:0], qbit};
        end
    end

    assign o_valid = r_v[NS];
    assign o_ovf   = r_ovf[NS];
    assign o_quot  = r_q[NS];
endmodule

@@ sv/pit_back.sv @@
// Back part: divides both barycentric numerators and applies the inside test.
// Depends on pit_pkg and pit_div.
module pit_back
    import pit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int QUOT_FRAC_BITS = QUOT_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [2*COORD_BITS+2:0] i_nu,
    input  logic [2*COORD_BITS+2:0] i_nv,
    input  logic [2*COORD_BITS+2:0] i_den,
    output logic                    o_done,
    output logic                    o_inside,
    output logic                    o_degenerate
);
    localparam int XW  = 2 * COORD_BITS + 3;
    localparam int MW  = 2 * COORD_BITS + 2;
    localparam int F   = QUOT_FRAC_BITS;
    localparam int LAT = F + 3;
    localparam int SW  = F + 5;
    localparam int ONE = 1 << F;
    localparam int TOL = ONE / 10000;
    localparam logic signed [SW-1:0] LIM_LO = SW'(-TOL);
    localparam logic signed [SW-1:0] LIM_HI = SW'(ONE + TOL);

    logic          r_v;
    logic [MW-1:0] r_mu, r_mv, r_md;
    logic          r_neg_u, r_neg_v, r_deg;
    logic          sb_neg_u [0:LAT-1];
    logic          sb_neg_v [0:LAT-1];
    logic          sb_deg   [0:LAT-1];

    logic          u_valid, u_ovf, v_valid, v_ovf;
    logic [F+1:0]  u_q, v_q;
    logic [F+2:0]  u_mag, v_mag;
    logic signed [SW-1:0] u_s, v_s, uv_s;
    logic          n_inside;
    logic          r_done, r_inside, r_degen;

    function automatic logic [MW-1:0] mag(input logic [XW-1:0] x);
        logic [XW-1:0] a;
        a = x[XW-1] ? (~x + 1'b1) : x;
        return a[MW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mu    <= mag(i_nu);
        r_mv    <= mag(i_nv);
        r_md    <= mag(i_den);
        r_neg_u <= i_nu[XW-1] ^ i_den[XW-1];
        r_neg_v <= i_nv[XW-1] ^ i_den[XW-1];
        r_deg   <= (i_den == '0);
        sb_neg_u[0] <= r_neg_u;
        sb_neg_v[0] <= r_neg_v;
        sb_deg[0]   <= r_deg;
        for (int k = 1; k < LAT; k++) begin
            sb_neg_u[k] <= sb_neg_u[k-1];
            sb_neg_v[k] <= sb_neg_v[k-1];
            sb_deg[k]   <= sb_deg[k-1];
        end
    end

    pit_div #(.MW(MW), .QUOT_FRAC_BITS(F)) u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v),
        .i_num   (r_mu),
        .i_den   (r_md),
        .o_valid (u_valid),
        .o_ovf   (u_ovf),
        .o_quot  (u_q)
    );

    pit_div #(.MW(MW), .QUOT_FRAC_BITS(F)) u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v),
        .i_num   (r_mv),
        .i_den   (r_md),
        .o_valid (v_valid),
        .o_ovf   (v_ovf),
        .o_quot  (v_q)
    );

    always_comb begin
        u_mag    = u_ovf ? (F+3)'(4 * ONE) : {1'b0, u_q};
        v_mag    = v_ovf ? (F+3)'(4 * ONE) : {1'b0, v_q};
        u_s      = sb_neg_u[LAT-1] ? -$signed(SW'(u_mag)) : $signed(SW'(u_mag));
        v_s      = sb_neg_v[LAT-1] ? -$signed(SW'(v_mag)) : $signed(SW'(v_mag));
        uv_s     = u_s + v_s;
        n_inside = !sb_deg[LAT-1] && (u_s >= LIM_LO) && (v_s >= LIM_LO) && (uv_s <= LIM_HI);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b0;
            r_inside <= 1'b0;
            r_degen  <= 1'b0;
        end else begin
            r_done   <= u_valid && v_valid;
            r_inside <= u_valid && n_inside;
            r_degen  <= u_valid && sb_deg[LAT-1];
        end
    end

    assign o_done       = r_done;
    assign o_inside     = r_inside;
    assign o_degenerate = r_degen;
endmodule

@@ dv/tb.sv @@
// Testbench for point_in_triangle_test: drives points against vertex settings
// and checks each result against a barycentric predictor. Depends on pit_pkg.
module tb;
    import pit_pkg::*;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } t_verdict;

    class t_verdict_board;
        t_verdict pending[$];
        int errors = 0;

        function void note_point(t_verdict v);
            pending.push_back(v);
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %b", got);
                return;
            end
            want = pending.pop_front();
            if (want !== got) begin
                errors++;
                if (errors <= 10)
                    $display("result: expected inside=%b degen=%b, got inside=%b degen=%b",
                             want.inside_res, want.degenerate, got.inside_res,
                             got.degenerate);
            end
        endfunction
    endclass

    localparam longint ONE = 64'sd65536;
    localparam longint TOL = 64'sd6;
    localparam int LATENCY = 25;
    localparam int WATCHDOG = 2000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_start = 0;
    logic o_busy;
    logic [15:0] i_point_x = 0;
    logic [15:0] i_point_y = 0;
    logic i_cfg_we = 0;
    logic [IDX_W-1:0] i_cfg_idx = 0;
    logic [15:0] i_cfg_data = 0;
    logic o_done, o_inside_res, o_degenerate;

    logic signed [15:0] vertex[6];
    t_verdict_board board;
    int stall_cycles = 0;
    bit timed_out = 0;
    bit no_gaps = 0;

    point_in_triangle_test u_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic longint barycentric_weight(longint n, longint d);
        bit neg;
        longint un, ud, whole, rem, frac, mag;
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        whole = un / ud;
        if (whole >= 4) begin
            mag = 4 * ONE;
        end else begin
            rem = un - whole * ud;
            frac = 0;
            for (int i = 0; i < 16; i++) begin
                rem = rem << 1;
                frac = frac << 1;
                if (rem >= ud) begin
                    rem -= ud;
                    frac |= 1;
                end
            end
            mag = (whole << 16) | frac;
        end
        return neg ? -mag : mag;
    endfunction

    function automatic t_verdict classify_point(logic signed [15:0] px,
                                                logic signed [15:0] py);
        t_verdict r;
        longint e0x, e0y, e1x, e1y, qx, qy, den, u, v;
        e0x = longint'(vertex[REG_C_X]) - vertex[REG_A_X];
        e0y = longint'(vertex[REG_C_Y]) - vertex[REG_A_Y];
        e1x = longint'(vertex[REG_B_X]) - vertex[REG_A_X];
        e1y = longint'(vertex[REG_B_Y]) - vertex[REG_A_Y];
        qx = longint'(px) - vertex[REG_A_X];
        qy = longint'(py) - vertex[REG_A_Y];
        den = e0x * e1y - e0y * e1x;
        r.degenerate = (den == 0);
        r.inside_res = 0;
        if (den != 0) begin
            u = barycentric_weight(qx * e1y - qy * e1x, den);
            v = barycentric_weight(e0x * qy - e0y * qx, den);
            r.inside_res = (u >= -TOL) && (v >= -TOL) && (u + v <= ONE + TOL);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (o_done && i_rst_n) board.check_verdict({o_inside_res, o_degenerate});
        if ((i_start && !o_busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("point_in_triangle_test: mismatch");
            $finish;
        end
    end

    task automatic write_vertex(logic [IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx < 6) vertex[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic set_triangle(logic [15:0] ax, ay, bx, by, cx, cy);
        write_vertex(REG_A_X, ax);
        write_vertex(REG_A_Y, ay);
        write_vertex(REG_B_X, bx);
        write_vertex(REG_B_Y, by);
        write_vertex(REG_C_X, cx);
        write_vertex(REG_C_Y, cy);
    endtask

    // Start stays high between items, bar random gaps, for back-to-back points.
    task automatic send_point(logic [15:0] px, logic [15:0] py);
        while (!no_gaps && $urandom_range(99) < 19) begin
            i_start <= 0;
            @(posedge i_clk);
        end
        i_start <= 1;
        i_point_x <= px;
        i_point_y <= py;
        do @(negedge i_clk); while (o_busy);
        @(posedge i_clk);
        board.note_point(classify_point(px, py));
    endtask

    task automatic drain;
        i_start <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [15:0] near_coord(logic signed [15:0] c);
        return c + $signed(16'($urandom_range(0, 400))) - 16'sd200;
    endfunction

    task automatic random_points(int n);
        logic [15:0] px, py;
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(9);
            if (pick < 7) begin
                px = near_coord(vertex[$urandom_range(2) * 2]);
                py = near_coord(vertex[$urandom_range(2) * 2 + 1]);
            end else begin
                px = $urandom;
                py = $urandom;
            end
            send_point(px, py);
        end
    endtask

    task automatic random_triangle;
        for (int i = 0; i < 6; i++)
            write_vertex(IDX_W'(i), $signed(16'($urandom_range(0, 800))) - 16'sd400);
    endtask

    initial begin
        board = new();
        foreach (vertex[i]) vertex[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        send_point(16'h1234, 16'h8000);
        drain();
        set_triangle(16'd0, 16'd0, 16'd160, 16'd0, 16'd0, 16'd160);
        send_point(16'd0, 16'd0);
        send_point(16'd160, 16'd0);
        send_point(16'd0, 16'd160);
        send_point(16'd80, 16'd80);
        send_point(16'd81, 16'd80);
        send_point(16'd40, 16'd40);
        send_point(16'hFFFF, 16'd10);
        send_point(16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000);
        send_point(16'hFFFF, 16'hFFFF);
        drain();
        write_vertex(3'd6, 16'h5555);
        write_vertex(3'd7, 16'hAAAA);
        set_triangle(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_point(16'h0000, 16'h0000);
        send_point(16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000);
        send_point(16'h8001, 16'h0001);
        drain();
        set_triangle(16'd10, 16'd10, 16'd20, 16'd20, 16'd30, 16'd30);
        send_point(16'd20, 16'd20);
        send_point(16'hA5A5, 16'h5A5A);
        drain();
        for (int phase = 0; phase < 8; phase++) begin
            no_gaps = (phase == 3);
            if (phase == 5)
                set_triangle(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
            else
                random_triangle();
            random_points(50);
            drain();
        end
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("point_in_triangle_test: match");
        end else begin
            $display("point_in_triangle_test: mismatch");
        end
        $finish;
    end
endmodule
